// File: design/sif_pkg.sv
package sif_pkg;

  // default geometry of the datapath
  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 14;

endpackage

// File: design/segment_intersection_fixed.sv
// Registers from request acceptance to out_valid: stages 1-3, divider 0 .. LAST, check, scaling, output.
// Throughput: one request per cycle unless in_stall. The two fixed-point dividers run one
//   quotient bit per pipeline stage, so the divide chain sets the depth but not the rate.
// Backpressure: a one-entry skid register behind the output register; in_stall is
//   high only while that skid entry is occupied.
// Reset (rst, synchronous, active high) clears all valid bits; data registers are not reset.
module segment_intersection_fixed #(
  parameter int COORD_BITS    = sif_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = sif_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] hit_x,
  output logic signed [COORD_BITS-1:0] hit_y
);

  // Widths:
  //   DW  - coordinate differences (one bit of growth)
  //   PW  - products of two differences
  //   NW  - denominator / numerators (difference of two products), also magnitudes
  //   QW  - quotient: one integer bit plus FRACTION_BITS
  //   XW  - quotient times a difference
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int QW   = FRACTION_BITS + 1;
  localparam int XW   = QW + 1 + DW;
  localparam int LAST = FRACTION_BITS + 1;  // last divider stage index

  localparam logic [QW-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

  // Whole pipeline moves together; it only freezes when the skid entry is full.
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // ---------------------------------------------------------------------------
  // Stage 1: endpoint differences
  // ---------------------------------------------------------------------------
  logic                         s1_v;
  logic signed [COORD_BITS-1:0] s1_ax, s1_ay;
  logic signed [DW-1:0]         s1_dxa, s1_dya, s1_dxb, s1_dyb, s1_ox, s1_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_ax  <= a_start_x;
      s1_ay  <= a_start_y;
      s1_dxa <= DW'(a_end_x) - DW'(a_start_x);
      s1_dya <= DW'(a_end_y) - DW'(a_start_y);
      s1_dxb <= DW'(b_end_x) - DW'(b_start_x);
      s1_dyb <= DW'(b_end_y) - DW'(b_start_y);
      s1_ox  <= DW'(a_start_x) - DW'(b_start_x);
      s1_oy  <= DW'(a_start_y) - DW'(b_start_y);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the six cross products
  // ---------------------------------------------------------------------------
  logic                         s2_v;
  logic signed [COORD_BITS-1:0] s2_ax, s2_ay;
  logic signed [DW-1:0]         s2_dxa, s2_dya;
  logic signed [PW-1:0]         s2_p_d0, s2_p_d1, s2_p_a0, s2_p_a1, s2_p_b0, s2_p_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
      s2_dxa  <= s1_dxa;
      s2_dya  <= s1_dya;
      s2_p_d0 <= s1_dyb * s1_dxa;
      s2_p_d1 <= s1_dxb * s1_dya;
      s2_p_a0 <= s1_dxb * s1_oy;
      s2_p_a1 <= s1_dyb * s1_ox;
      s2_p_b0 <= s1_dxa * s1_oy;
      s2_p_b1 <= s1_dya * s1_ox;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: denominator and numerators
  // ---------------------------------------------------------------------------
  logic                         s3_v;
  logic signed [COORD_BITS-1:0] s3_ax, s3_ay;
  logic signed [DW-1:0]         s3_dxa, s3_dya;
  logic signed [NW-1:0]         s3_d, s3_na, s3_nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_dxa <= s2_dxa;
      s3_dya <= s2_dya;
      s3_d   <= NW'(s2_p_d0) - NW'(s2_p_d1);
      s3_na  <= NW'(s2_p_a0) - NW'(s2_p_a1);
      s3_nb  <= NW'(s2_p_b0) - NW'(s2_p_b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline, two lanes (ua, ub) sharing the denominator magnitude.
  //   index 0         : sign split, magnitudes
  //   index 1         : integer quotient bit plus overflow (quotient >= 2)
  //   index 2 .. LAST : one fractional quotient bit per stage (restoring)
  // ---------------------------------------------------------------------------
  logic                         dv_v   [0:LAST];
  logic signed [COORD_BITS-1:0] dv_ax  [0:LAST];
  logic signed [COORD_BITS-1:0] dv_ay  [0:LAST];
  logic signed [DW-1:0]         dv_dxa [0:LAST];
  logic signed [DW-1:0]         dv_dya [0:LAST];
  logic                         dv_dz  [0:LAST];
  logic                         dv_nega[0:LAST];
  logic                         dv_negb[0:LAST];
  logic                         dv_ova [0:LAST];
  logic                         dv_ovb [0:LAST];
  logic [NW-1:0]                dv_ad  [0:LAST];
  logic [NW-1:0]                dv_ra  [0:LAST];
  logic [NW-1:0]                dv_rb  [0:LAST];
  logic [QW-1:0]                dv_qa  [0:LAST];
  logic [QW-1:0]                dv_qb  [0:LAST];

  // index 0: magnitudes; the most negative value still fits as unsigned NW bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= s3_v;
    end
    if (en) begin
      dv_ax[0]   <= s3_ax;
      dv_ay[0]   <= s3_ay;
      dv_dxa[0]  <= s3_dxa;
      dv_dya[0]  <= s3_dya;
      dv_dz[0]   <= (s3_d == '0);
      dv_nega[0] <= s3_na[NW-1] ^ s3_d[NW-1];
      dv_negb[0] <= s3_nb[NW-1] ^ s3_d[NW-1];
      dv_ova[0]  <= 1'b0;
      dv_ovb[0]  <= 1'b0;
      dv_ad[0]   <= s3_d[NW-1]  ? NW'(-s3_d)  : NW'(s3_d);
      dv_ra[0]   <= s3_na[NW-1] ? NW'(-s3_na) : NW'(s3_na);
      dv_rb[0]   <= s3_nb[NW-1] ? NW'(-s3_nb) : NW'(s3_nb);
      dv_qa[0]   <= '0;
      dv_qb[0]   <= '0;
    end
  end

  // index 1: integer part; remainder left below the divisor unless overflow is flagged
  logic          int_ge_a, int_ge_b;
  logic [NW-1:0] int_ra, int_rb;

  always_comb begin
    int_ge_a = (dv_ra[0] >= dv_ad[0]);
    int_ge_b = (dv_rb[0] >= dv_ad[0]);
    int_ra   = int_ge_a ? (dv_ra[0] - dv_ad[0]) : dv_ra[0];
    int_rb   = int_ge_b ? (dv_rb[0] - dv_ad[0]) : dv_rb[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[1] <= 1'b0;
    end else if (en) begin
      dv_v[1] <= dv_v[0];
    end
    if (en) begin
      dv_ax[1]   <= dv_ax[0];
      dv_ay[1]   <= dv_ay[0];
      dv_dxa[1]  <= dv_dxa[0];
      dv_dya[1]  <= dv_dya[0];
      dv_dz[1]   <= dv_dz[0];
      dv_nega[1] <= dv_nega[0];
      dv_negb[1] <= dv_negb[0];
      dv_ova[1]  <= ({1'b0, dv_ra[0]} >= {dv_ad[0], 1'b0});
      dv_ovb[1]  <= ({1'b0, dv_rb[0]} >= {dv_ad[0], 1'b0});
      dv_ad[1]   <= dv_ad[0];
      dv_ra[1]   <= int_ra;
      dv_rb[1]   <= int_rb;
      dv_qa[1]   <= QW'(int_ge_a);
      dv_qb[1]   <= QW'(int_ge_b);
    end
  end

  // index 2 .. LAST: fractional bits
  for (genvar k = 2; k <= LAST; k++) begin : g_frac
    logic [NW:0]   ta, tb;
    logic          ge_a, ge_b;
    logic [NW-1:0] ra_next, rb_next;

    always_comb begin
      ta      = {dv_ra[k-1], 1'b0};
      tb      = {dv_rb[k-1], 1'b0};
      ge_a    = (ta >= {1'b0, dv_ad[k-1]});
      ge_b    = (tb >= {1'b0, dv_ad[k-1]});
      ra_next = ge_a ? NW'(ta - {1'b0, dv_ad[k-1]}) : NW'(ta);
      rb_next = ge_b ? NW'(tb - {1'b0, dv_ad[k-1]}) : NW'(tb);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= dv_v[k-1];
      end
      if (en) begin
        dv_ax[k]   <= dv_ax[k-1];
        dv_ay[k]   <= dv_ay[k-1];
        dv_dxa[k]  <= dv_dxa[k-1];
        dv_dya[k]  <= dv_dya[k-1];
        dv_dz[k]   <= dv_dz[k-1];
        dv_nega[k] <= dv_nega[k-1];
        dv_negb[k] <= dv_negb[k-1];
        dv_ova[k]  <= dv_ova[k-1];
        dv_ovb[k]  <= dv_ovb[k-1];
        dv_ad[k]   <= dv_ad[k-1];
        dv_ra[k]   <= ra_next;
        dv_rb[k]   <= rb_next;
        dv_qa[k]   <= {dv_qa[k-1][QW-2:0], ge_a};
        dv_qb[k]   <= {dv_qb[k-1][QW-2:0], ge_b};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Range check: a parameter is in range when it truncates to zero (either
  // sign), or it is non-negative and at most one. Overflow means quotient >= 2.
  // ---------------------------------------------------------------------------
  logic ok_a, ok_b;

  always_comb begin
    ok_a = !dv_ova[LAST] &&
           ((dv_qa[LAST] == '0) || (!dv_nega[LAST] && (dv_qa[LAST] <= ONE_FIX)));
    ok_b = !dv_ovb[LAST] &&
           ((dv_qb[LAST] == '0) || (!dv_negb[LAST] && (dv_qb[LAST] <= ONE_FIX)));
  end

  logic                         ck_v;
  logic                         ck_hit;
  logic [QW-1:0]                ck_ua;
  logic signed [COORD_BITS-1:0] ck_ax, ck_ay;
  logic signed [DW-1:0]         ck_dxa, ck_dya;

  always_ff @(posedge clk) begin
    if (rst) begin
      ck_v <= 1'b0;
    end else if (en) begin
      ck_v <= dv_v[LAST];
    end
    if (en) begin
      ck_hit <= !dv_dz[LAST] && ok_a && ok_b;
      ck_ua  <= dv_qa[LAST];
      ck_ax  <= dv_ax[LAST];
      ck_ay  <= dv_ay[LAST];
      ck_dxa <= dv_dxa[LAST];
      ck_dya <= dv_dya[LAST];
    end
  end

  // ---------------------------------------------------------------------------
  // Hit point scaling: ua * delta along segment A
  // ---------------------------------------------------------------------------
  logic                         mu_v;
  logic                         mu_hit;
  logic signed [COORD_BITS-1:0] mu_ax, mu_ay;
  logic signed [XW-1:0]         mu_px, mu_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_v <= 1'b0;
    end else if (en) begin
      mu_v <= ck_v;
    end
    if (en) begin
      mu_hit <= ck_hit;
      mu_ax  <= ck_ax;
      mu_ay  <= ck_ay;
      mu_px  <= $signed({1'b0, ck_ua}) * ck_dxa;
      mu_py  <= $signed({1'b0, ck_ua}) * ck_dya;
    end
  end

  // floor shift, then offset from A's start; the point always fits COORD_BITS
  logic signed [XW-1:0]         sh_x, sh_y;
  logic                         res_hit;
  logic signed [COORD_BITS-1:0] res_x, res_y;

  always_comb begin
    sh_x    = mu_px >>> FRACTION_BITS;
    sh_y    = mu_py >>> FRACTION_BITS;
    res_hit = mu_hit;
    res_x   = mu_hit ? (mu_ax + sh_x[COORD_BITS-1:0]) : '0;
    res_y   = mu_hit ? (mu_ay + sh_y[COORD_BITS-1:0]) : '0;
  end

  // ---------------------------------------------------------------------------
  // Output register plus one-entry skid. The skid catches the item leaving
  // the pipeline in the cycle the output is found stalled.
  // ---------------------------------------------------------------------------
  logic                         skid_hit;
  logic signed [COORD_BITS-1:0] skid_x, skid_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= mu_v;
      end
    end else if (mu_v && en) begin
      skid_valid <= 1'b1;
    end

    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        hit   <= skid_hit;
        hit_x <= skid_x;
        hit_y <= skid_y;
      end else begin
        hit   <= res_hit;
        hit_x <= res_x;
        hit_y <= res_y;
      end
    end else if (mu_v && en) begin
      skid_hit <= res_hit;
      skid_x   <= res_x;
      skid_y   <= res_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // the skid entry only fills while a result sits stalled at the output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  // a held skid entry implies the output register is occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid occupied with empty output register");

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (hit_x == '0 && hit_y == '0))
    else $error("miss with nonzero coordinates");

endmodule

// File: bench/segment_intersection_fixed_tb.sv
`timescale 1ns / 1ps

module segment_intersection_fixed_tb;

  localparam int CW = sif_pkg::COORD_BITS_DEF;
  localparam int FB = sif_pkg::FRACTION_BITS_DEF;
  // Drain length covers the pipeline depth with slack past it.
  localparam int DRAIN_CYCLES = FB + 24;
  // Watchdog limit, many times over the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;

  // One request: both segments, endpoints as two's complement coordinates.
  typedef struct packed {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1;
    logic signed [CW-1:0] bx0, by0, bx1, by1;
  } seg_pair_t;

  // One result: hit flag and the point on segment A.
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input starts at a known value.
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] a_start_x = '0;
  logic signed [CW-1:0] a_start_y = '0;
  logic signed [CW-1:0] a_end_x   = '0;
  logic signed [CW-1:0] a_end_y   = '0;
  logic signed [CW-1:0] b_start_x = '0;
  logic signed [CW-1:0] b_start_y = '0;
  logic signed [CW-1:0] b_end_x   = '0;
  logic signed [CW-1:0] b_end_y   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic signed [CW-1:0] hit_x;
  logic signed [CW-1:0] hit_y;

  // Predicted crossings, oldest first, one per accepted request.
  crossing_t pending_crossings[$];

  int error_count = 0;
  int cycle_count = 0;
  // Idle rates in percent for the request side and the result side.
  int req_idle_pct = 12;
  int res_idle_pct = 12;

  segment_intersection_fixed i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_start_x (a_start_x),
    .a_start_y (a_start_y),
    .a_end_x   (a_end_x),
    .a_end_y   (a_end_y),
    .b_start_x (b_start_x),
    .b_start_y (b_start_y),
    .b_end_x   (b_end_x),
    .b_end_y   (b_end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .hit_x     (hit_x),
    .hit_y     (hit_y)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Crossing predictor
  // ---------------------------------------------------------------------------

  // Fixed-point segment parameter (num << FB) / den, truncated toward zero.
  // Returns 1 when it lies in 0 .. 1.0. A negative value that truncates to
  // zero counts as zero, so it is in range.
  function automatic bit seg_param(input longint num, input longint den,
                                   output longint q);
    bit     neg;
    longint an;
    longint ad;
    longint mag;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    // |num| stays below 2^34, so the shift cannot overflow 64 bits
    mag = (an << FB) / ad;
    q   = 0;
    if (mag == 0)
      return 1'b1;
    if (neg || mag > (longint'(1) << FB))
      return 1'b0;
    q = mag;
    return 1'b1;
  endfunction

  function automatic crossing_t predict_crossing(input seg_pair_t p);
    crossing_t r;
    longint    ax0, ay0, bx0, by0;
    longint    dxa, dya, dxb, dyb, ox, oy;
    longint    den, num_a, num_b, ua, ub;
    ax0   = p.ax0;
    ay0   = p.ay0;
    bx0   = p.bx0;
    by0   = p.by0;
    dxa   = longint'(p.ax1) - ax0;
    dya   = longint'(p.ay1) - ay0;
    dxb   = longint'(p.bx1) - bx0;
    dyb   = longint'(p.by1) - by0;
    ox    = ax0 - bx0;
    oy    = ay0 - by0;
    den   = dyb * dxa - dxb * dya;
    num_a = dxb * oy - dyb * ox;
    num_b = dxa * oy - dya * ox;
    r     = '0;
    // parallel or collinear: always a miss
    if (den == 0)
      return r;
    if (!seg_param(num_a, den, ua) || !seg_param(num_b, den, ub))
      return r;
    r.hit = 1'b1;
    // floor shift: the point lies on A, so it always fits in CW bits
    r.x = CW'(ax0 + ((ua * dxa) >>> FB));
    r.y = CW'(ay0 + ((ua * dya) >>> FB));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    longint top;
    top = (longint'(1) << (CW - 1)) - 1;
    if (v > top)
      return CW'(top);
    if (v < -top - 1)
      return CW'(-top - 1);
    return CW'(v);
  endfunction

  // Random coordinate: full range, small, medium, or pinned near the rails.
  function automatic logic signed [CW-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 4);
    case (sel)
      0, 1: return CW'($urandom);
      2: return clamp_coord(int'($urandom_range(0, 32)) - 16);
      3: return clamp_coord(int'($urandom_range(0, 2048)) - 1024);
      default: begin
        if ($urandom_range(0, 1))
          return clamp_coord(32767 - int'($urandom_range(0, 3)));
        return clamp_coord(-32768 + int'($urandom_range(0, 3)));
      end
    endcase
  endfunction

  function automatic seg_pair_t pair_of(input int ax0, ay0, ax1, ay1,
                                        input int bx0, by0, bx1, by1);
    seg_pair_t p;
    p.ax0 = CW'(ax0);
    p.ay0 = CW'(ay0);
    p.ax1 = CW'(ax1);
    p.ay1 = CW'(ay1);
    p.bx0 = CW'(bx0);
    p.by0 = CW'(by0);
    p.bx1 = CW'(bx1);
    p.by1 = CW'(by1);
    return p;
  endfunction

  // Drive one request and hold it until accepted. Random idle cycles come
  // first; in_valid is only raised after them, so it never drops mid-request.
  task automatic send_pair(input seg_pair_t p);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    a_start_x <= p.ax0;
    a_start_y <= p.ay0;
    a_end_x   <= p.ax1;
    a_end_y   <= p.ay1;
    b_start_x <= p.bx0;
    b_start_y <= p.by0;
    b_end_x   <= p.bx1;
    b_end_y   <= p.by1;
    @(posedge clk);
    // in_stall read here is the value the block saw at this edge
    while (in_stall)
      @(posedge clk);
    pending_crossings.push_back(predict_crossing(p));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // plain X crossing at the origin
    send_pair(pair_of(-100, 0, 100, 0, 0, -100, 0, 100));
    // parallel, apart
    send_pair(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
    // collinear and overlapping still reads as a miss
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    // both segments collapsed to the same point
    send_pair(pair_of(7, -7, 7, -7, 7, -7, 7, -7));
    // A collapsed, B real
    send_pair(pair_of(3, 3, 3, 3, 0, 0, 10, 10));
    // B touches the start of A: ua = 0
    send_pair(pair_of(0, 0, 10, 0, 0, -5, 0, 5));
    // B touches the end of A: ua = 1.0
    send_pair(pair_of(-10, 0, 0, 0, 0, -5, 0, 5));
    // A touches the end of B: ub = 1.0
    send_pair(pair_of(-5, 0, 5, 0, 0, 10, 0, 0));
    // B passes just before the start of A; ua is negative but truncates to 0
    send_pair(pair_of(0, 0, 32000, 0, -1, -30000, -1, 30000));
    // quotient far out of range, flagged as overflow in the divider
    send_pair(pair_of(0, 0, 1, 0, 30000, -5, 30000, 5));
    // just past the end of A
    send_pair(pair_of(0, 0, 100, 0, 101, -1, 101, 1));
    // full-scale diagonals
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    // shared corner at the most negative coordinates
    send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767));
    // everything at the positive rail
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    // negative deltas, floor rounding on the hit point
    send_pair(pair_of(10, 10, -7, 3, 0, 20, 3, -20));
    send_pair(pair_of(-3, 5, 11, -9, -8, -8, 9, 6));
    // apart, not parallel
    send_pair(pair_of(0, 0, 10, 10, 20, 0, 30, -10));
    // alternating bit patterns on every field
    send_pair(pair_of(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
                      16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555));
    send_pair(pair_of(16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA,
                      16'sh5555, 16'sh5555, 16'shAAAA, 16'shAAAA));
  endtask

  // Well-formed crossings: B is built through a point P on A, so most of
  // these hit; clamped or short ones become near misses.
  task automatic test_crossings(input int count);
    seg_pair_t p;
    longint    px, py, vx, vy, k;
    int        t, mag;
    repeat (count) begin
      p.ax0 = pick_coord();
      p.ay0 = pick_coord();
      p.ax1 = pick_coord();
      p.ay1 = pick_coord();
      t  = $urandom_range(0, 256);
      px = longint'(p.ax0) + (longint'(p.ax1) - p.ax0) * t / 256;
      py = longint'(p.ay0) + (longint'(p.ay1) - p.ay0) * t / 256;
      case ($urandom_range(0, 3))
        0: mag = 15;
        1: mag = 255;
        2: mag = 4095;
        default: mag = 32767;
      endcase
      vx = longint'($urandom_range(0, 2 * mag)) - mag;
      vy = longint'($urandom_range(0, 2 * mag)) - mag;
      k  = $urandom_range(1, 3);
      p.bx0 = clamp_coord(px - vx);
      p.by0 = clamp_coord(py - vy);
      p.bx1 = clamp_coord(px + k * vx);
      p.by1 = clamp_coord(py + k * vy);
      send_pair(p);
    end
  endtask

  // Unstructured requests: every field random, including full-width values.
  task automatic test_noise(input int count);
    seg_pair_t p;
    repeat (count) begin
      if ($urandom_range(0, 1))
        p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      else
        p = pair_of(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord(), pick_coord());
      send_pair(p);
    end
  endtask

  // Zero denominators: shifted copies (parallel or collinear), reversed
  // copies and collapsed segments.
  task automatic test_degenerate(input int count);
    seg_pair_t p;
    longint    ox, oy;
    repeat (count) begin
      p.ax0 = pick_coord();
      p.ay0 = pick_coord();
      p.ax1 = pick_coord();
      p.ay1 = pick_coord();
      ox = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 200)) - 100;
      oy = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 200)) - 100;
      case ($urandom_range(0, 3))
        0: begin
          p.bx0 = clamp_coord(p.ax0 + ox);
          p.by0 = clamp_coord(p.ay0 + oy);
          p.bx1 = clamp_coord(p.ax1 + ox);
          p.by1 = clamp_coord(p.ay1 + oy);
        end
        1: begin
          p.bx0 = clamp_coord(p.ax1 + ox);
          p.by0 = clamp_coord(p.ay1 + oy);
          p.bx1 = clamp_coord(p.ax0 + ox);
          p.by1 = clamp_coord(p.ay0 + oy);
        end
        2: begin
          p.ax1 = p.ax0;
          p.ay1 = p.ay0;
          p.bx0 = pick_coord();
          p.by0 = pick_coord();
          p.bx1 = pick_coord();
          p.by1 = pick_coord();
        end
        default: begin
          p.bx0 = pick_coord();
          p.by0 = pick_coord();
          p.bx1 = p.bx0;
          p.by1 = p.by0;
        end
      endcase
      send_pair(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random result stall, driven by its own idle rate knob, res_idle_pct.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < res_idle_pct);
  end

  // Compare every accepted result against the oldest predicted crossing.
  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_crossings.size() == 0) begin
        $error("result with no request outstanding: hit=%0b x=%0d y=%0d",
               hit, hit_x, hit_y);
        error_count++;
      end else begin
        exp_c = pending_crossings.pop_front();
        if (hit !== exp_c.hit) begin
          $error("hit: expected %0b, got %0b", exp_c.hit, hit);
          error_count++;
        end
        if (hit_x !== exp_c.x) begin
          $error("hit_x: expected %0d, got %0d", exp_c.x, hit_x);
          error_count++;
        end
        if (hit_y !== exp_c.y) begin
          $error("hit_y: expected %0d, got %0d", exp_c.y, hit_y);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();

    // long stretch with no idling on either side: back-to-back requests
    req_idle_pct = 0;
    res_idle_pct = 0;
    test_crossings(300);
    req_idle_pct = 12;
    res_idle_pct = 12;

    test_crossings(800);
    test_noise(350);
    test_degenerate(250);
    test_crossings(200);
    test_noise(50);

    in_valid <= 1'b0;
    // drain: every outstanding result, then a quiet tail for stray outputs
    while (pending_crossings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
